@@ hdl/ajb_pkg.sv @@
// Shared types, codes and sequence helpers for the audio jitter buffer.
package ajb_pkg;

  localparam int CAPACITY_DEF = 16;

  // Field widths
  localparam int ACT_W     = 2;
  localparam int WORD_W    = 32;
  localparam int LEN_W     = 12;
  localparam int PRE_W     = 5;
  localparam int MISS_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int BCOUNT_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 272;

  // Actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TAKE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STATS  = 2'd3;

  // Take status codes
  localparam logic [STATUS_W-1:0] TAKE_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] TAKE_PACKET  = 2'd1;
  localparam logic [STATUS_W-1:0] TAKE_SILENCE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREBUFFER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP      = 2'd3;

  // Register reset values
  localparam logic [PRE_W-1:0]  PREBUFFER_RST = 5'd3;
  localparam logic [MISS_W-1:0] MISS_LIM_RST  = 8'd5;
  localparam logic [LEN_W-1:0]  PAYLOAD_RST   = 12'd640;
  localparam logic [WORD_W-1:0] JUMP_RST      = 32'd1000;

  // Statistics counter slots
  localparam int NUM_STATS   = 6;
  localparam int ST_INSERTED = 0;
  localparam int ST_LATE     = 1;
  localparam int ST_DUP      = 2;
  localparam int ST_OVERFLOW = 3;
  localparam int ST_CONCEAL  = 4;
  localparam int ST_RESTART  = 5;

  typedef struct packed {
    logic latch;
    logic prep;
    logic scan;
    logic fin;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic prep_stop;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

  // a precedes b in wrapping sequence order
  function automatic logic seq_before(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] d;
    d = a - b;
    return (a != b) && d[WORD_W-1];
  endfunction

  // successor that skips zero
  function automatic logic [WORD_W-1:0] seq_next(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] n;
    n = s + 32'd1;
    return (n == '0) ? 32'd1 : n;
  endfunction

endpackage

@@ hdl/ajb_ctrl.sv @@
// Sequencing state machine for the audio jitter buffer.
module ajb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ajb_pkg::dp_sts_t   sts,
  output ajb_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.prep_stop ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/ajb_datapath.sv @@
// Packet table, session state, statistics and output register.
module ajb_datapath #(
  parameter int CAPACITY = ajb_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ajb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ajb_pkg::WORD_W-1:0]        cfg_data,
  input  logic [ajb_pkg::ACT_W-1:0]         in_action,
  input  logic [ajb_pkg::IN_DATA_W-1:0]     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ajb_pkg::OUT_DATA_W-1:0]    out_data,
  input  ajb_pkg::ctrl_cmd_t                cmd,
  output ajb_pkg::dp_sts_t                  sts
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ajb_pkg::PRE_W) ? CNT_W : ajb_pkg::PRE_W;
  localparam int W     = ajb_pkg::WORD_W;

  // Latched input word
  logic [ajb_pkg::ACT_W-1:0] act_q;
  logic [W-1:0]              sess_q;
  logic [W-1:0]              seq_q;
  logic [ajb_pkg::LEN_W-1:0] len_q;
  logic [W-1:0]              hdl_q;

  // Configuration
  logic [ajb_pkg::PRE_W-1:0]  pre_cnt;
  logic [ajb_pkg::MISS_W-1:0] miss_lim;
  logic [ajb_pkg::LEN_W-1:0]  pay_bytes;
  logic [W-1:0]               jump_lim;

  // Table and session state
  logic [CAPACITY-1:0]        valid;
  logic [CNT_W-1:0]           count;
  logic [W-1:0]               active;
  logic [W-1:0]               exp_seq;
  logic                       playing;
  logic [ajb_pkg::MISS_W-1:0] miss_run;
  logic [W-1:0]               stat [ajb_pkg::NUM_STATS];
  logic [W-1:0]               seq_mem [CAPACITY];
  logic [W-1:0]               hdl_mem [CAPACITY];

  // Scan state
  logic [IDX_W-1:0] scan_cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [W-1:0]     rd_seq;
  logic [W-1:0]     rd_hdl;
  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic [W-1:0]     match_hdl;
  logic             far_found;
  logic [IDX_W-1:0] far_idx;
  logic [W-1:0]     far_dist;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Result of the current word
  logic                         res_acc;
  logic [ajb_pkg::STATUS_W-1:0] res_status;
  logic [W-1:0]                 res_hdl;

  logic             new_sess, ins_invalid, late, jump, not_ready, full;
  logic             rd_v, evict_ok, mem_we;
  logic [W-1:0]     dist_new, key, rd_d, exp_next;
  logic [IDX_W-1:0] mem_addr;
  logic [ajb_pkg::MISS_W-1:0] miss_inc;

  // Decisions on the latched word
  always_comb begin
    new_sess    = (active == '0) || (active != sess_q);
    ins_invalid = (sess_q == '0) || (seq_q == '0) || (len_q != pay_bytes);
    dist_new    = seq_q - exp_seq;
    late        = !new_sess && playing && ajb_pkg::seq_before(seq_q, exp_seq);
    jump        = !new_sess && playing && !late && (dist_new > jump_lim);
    not_ready   = CMP_W'(count) < CMP_W'(pre_cnt);
    full        = (count == CNT_W'(CAPACITY));
    key         = (act_q == ajb_pkg::ACT_INSERT) ? seq_q : exp_seq;
    rd_v        = valid[rd_idx];
    rd_d        = rd_seq - exp_seq;
    exp_next    = ajb_pkg::seq_next(exp_seq);
    miss_inc    = miss_run + 8'd1;
    evict_ok    = far_found && (dist_new < far_dist);
    mem_we      = cmd.fin && (act_q == ajb_pkg::ACT_INSERT) && !match_found &&
                  (!full || evict_ok);
    mem_addr    = full ? far_idx : free_idx;
    case (act_q)
      ajb_pkg::ACT_INSERT: sts.prep_stop = ins_invalid || late;
      ajb_pkg::ACT_TAKE:   sts.prep_stop = !playing && not_ready;
      default:             sts.prep_stop = 1'b1;
    endcase
    sts.scan_last = (scan_cnt == IDX_W'(CAPACITY - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= in_action;
      sess_q <= in_data[31:0];
      seq_q  <= in_data[63:32];
      len_q  <= in_data[75:64];
      hdl_q  <= in_data[107:76];
    end
  end

  // Table memories: registered read at the scan address, one write port
  always_ff @(posedge clk) begin
    rd_seq <= seq_mem[scan_cnt];
    rd_hdl <= hdl_mem[scan_cnt];
    if (mem_we) begin
      seq_mem[mem_addr] <= seq_q;
      hdl_mem[mem_addr] <= hdl_q;
    end
  end

  // Control and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt     <= ajb_pkg::PREBUFFER_RST;
      miss_lim    <= ajb_pkg::MISS_LIM_RST;
      pay_bytes   <= ajb_pkg::PAYLOAD_RST;
      jump_lim    <= ajb_pkg::JUMP_RST;
      valid       <= '0;
      count       <= '0;
      active      <= '0;
      exp_seq     <= '0;
      playing     <= 1'b0;
      miss_run    <= '0;
      for (int i = 0; i < ajb_pkg::NUM_STATS; i++) stat[i] <= '0;
      scan_cnt    <= '0;
      rd_pend     <= 1'b0;
      rd_idx      <= '0;
      match_found <= 1'b0;
      match_idx   <= '0;
      match_hdl   <= '0;
      far_found   <= 1'b0;
      far_idx     <= '0;
      far_dist    <= '0;
      free_found  <= 1'b0;
      free_idx    <= '0;
      res_acc     <= 1'b0;
      res_status  <= ajb_pkg::TAKE_NONE;
      res_hdl     <= '0;
      out_valid   <= 1'b0;
      out_data    <= '0;
    end else begin
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          ajb_pkg::REG_PREBUFFER: pre_cnt   <= cfg_data[ajb_pkg::PRE_W-1:0];
          ajb_pkg::REG_MISS_LIM:  miss_lim  <= cfg_data[ajb_pkg::MISS_W-1:0];
          ajb_pkg::REG_PAYLOAD:   pay_bytes <= cfg_data[ajb_pkg::LEN_W-1:0];
          ajb_pkg::REG_JUMP:      jump_lim  <= cfg_data;
          default: ;
        endcase
      end

      // First step: checks, session handling, statistics reset, scan setup
      if (cmd.prep) begin
        scan_cnt    <= '0;
        rd_pend     <= 1'b0;
        match_found <= 1'b0;
        far_found   <= 1'b0;
        free_found  <= 1'b0;
        res_acc     <= 1'b0;
        res_status  <= ajb_pkg::TAKE_NONE;
        res_hdl     <= '0;
        case (act_q)
          ajb_pkg::ACT_INSERT: begin
            if (!ins_invalid) begin
              if (new_sess || jump) begin
                if (jump || active != '0)
                  stat[ajb_pkg::ST_RESTART] <= stat[ajb_pkg::ST_RESTART] + 32'd1;
                active   <= sess_q;
                exp_seq  <= seq_q;
                playing  <= 1'b0;
                miss_run <= '0;
                valid    <= '0;
                count    <= '0;
              end else if (late) begin
                stat[ajb_pkg::ST_LATE] <= stat[ajb_pkg::ST_LATE] + 32'd1;
              end else if (!playing && ajb_pkg::seq_before(seq_q, exp_seq)) begin
                exp_seq <= seq_q;
              end
            end
          end
          ajb_pkg::ACT_TAKE: begin
            if (!playing && !not_ready) begin
              playing  <= 1'b1;
              miss_run <= '0;
            end
          end
          ajb_pkg::ACT_CLEAR: begin
            active   <= '0;
            exp_seq  <= '0;
            playing  <= 1'b0;
            miss_run <= '0;
            valid    <= '0;
            count    <= '0;
          end
          default: begin
            for (int i = 0; i < ajb_pkg::NUM_STATS; i++) stat[i] <= '0;
          end
        endcase
      end

      // Advance the scan address
      if (cmd.scan) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
        rd_idx   <= scan_cnt;
        rd_pend  <= 1'b1;
      end else if (!cmd.prep) begin
        rd_pend <= 1'b0;
      end

      // Examine one entry: match, farthest valid entry, lowest free slot
      if (rd_pend) begin
        if (rd_v && rd_seq == key && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
          match_hdl   <= rd_hdl;
        end
        if (rd_v && (!far_found || rd_d > far_dist)) begin
          far_found <= 1'b1;
          far_idx   <= rd_idx;
          far_dist  <= rd_d;
        end
        if (!rd_v && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end

      // Last step: store, evict or play out
      if (cmd.fin) begin
        case (act_q)
          ajb_pkg::ACT_INSERT: begin
            if (match_found) begin
              stat[ajb_pkg::ST_DUP] <= stat[ajb_pkg::ST_DUP] + 32'd1;
            end else if (full) begin
              stat[ajb_pkg::ST_OVERFLOW] <= stat[ajb_pkg::ST_OVERFLOW] + 32'd1;
              if (evict_ok) begin
                stat[ajb_pkg::ST_INSERTED] <= stat[ajb_pkg::ST_INSERTED] + 32'd1;
                res_acc <= 1'b1;
              end
            end else begin
              valid[free_idx] <= 1'b1;
              count           <= count + CNT_W'(1);
              stat[ajb_pkg::ST_INSERTED] <= stat[ajb_pkg::ST_INSERTED] + 32'd1;
              res_acc <= 1'b1;
            end
          end
          ajb_pkg::ACT_TAKE: begin
            exp_seq <= exp_next;
            if (match_found) begin
              res_status       <= ajb_pkg::TAKE_PACKET;
              res_hdl          <= match_hdl;
              valid[match_idx] <= 1'b0;
              count            <= count - CNT_W'(1);
              miss_run         <= '0;
            end else begin
              res_status <= ajb_pkg::TAKE_SILENCE;
              stat[ajb_pkg::ST_CONCEAL] <= stat[ajb_pkg::ST_CONCEAL] + 32'd1;
              if (miss_inc >= miss_lim) begin
                playing  <= 1'b0;
                miss_run <= '0;
                valid    <= '0;
                count    <= '0;
              end else begin
                miss_run <= miss_inc;
              end
            end
          end
          default: ;
        endcase
      end

      // Output register
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        out_data  <= {7'd0, active,
                      stat[ajb_pkg::ST_RESTART], stat[ajb_pkg::ST_CONCEAL],
                      stat[ajb_pkg::ST_OVERFLOW], stat[ajb_pkg::ST_DUP],
                      stat[ajb_pkg::ST_LATE], stat[ajb_pkg::ST_INSERTED],
                      ajb_pkg::BCOUNT_W'(count), playing, res_hdl, res_status, res_acc};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/audio_jitter_buffer.sv @@
// Top level of the audio jitter buffer: controller plus datapath.
//
//  Channel   Signals                          Moves
//  s_axis    tvalid tready tdata tuser        one request word (insert/take/clear/stats)
//  m_axis    tvalid tready tdata              one result word per request
//  cfg       cfg_we cfg_index cfg_data        register write, no read-back
//
// Insert and take words go through a table scan, which
// reads one entry per cycle from the single memory read port.
// Rejected inserts, waiting takes, clear and stats reset skip the scan.
// One word is in work at a time; a result held by m_axis_tready stalls the next.
// rst is synchronous and clears the table, session, counters and registers.
module audio_jitter_buffer #(
  parameter int CAPACITY = ajb_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // session_id[31:0], seq_num[63:32], payload_length[75:64], payload_handle[107:76]
  input  logic [ajb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [ajb_pkg::ACT_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // insert_accepted[0], take_status[2:1], out_handle[34:3], is_playing[35],
  // buffered_count[40:36], inserted_total[72:41], late_total[104:73],
  // duplicate_total[136:105], overflow_total[168:137], concealed_total[200:169],
  // restart_total[232:201], current_session[264:233]
  output logic [ajb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [ajb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ajb_pkg::WORD_W-1:0]      cfg_data
);

  ajb_pkg::ctrl_cmd_t cmd;
  ajb_pkg::dp_sts_t   sts;

  ajb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ajb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_action (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
